/* src/tdp_pkg.sv */
package tdp_pkg;

   // Default operand width
   localparam int VALUE_BITS_DEF = 32;

   // Divisors for the multiple-of-two and multiple-of-three screen
   localparam int BASE_DIVISOR_A = 2;
   localparam int BASE_DIVISOR_B = 3;

   // Trial divisor sequence 6k-1 / 6k+1
   localparam int FIRST_DIVISOR  = 5;
   localparam int DIVISOR_STRIDE = 6;
   localparam int PAIR_OFFSET    = 2;

   // Running square of the divisor: (d+6)^2 = d^2 + 12d + 36
   localparam int FIRST_SQUARE   = FIRST_DIVISOR * FIRST_DIVISOR;
   localparam int SQUARE_STEP    = DIVISOR_STRIDE * DIVISOR_STRIDE;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE_WAIT,
      ST_BOUND,
      ST_PAIR_WAIT,
      ST_EMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic start_pair;
      logic step;
      logic set_verdict;
      logic verdict;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic rem_done;
      logic trivial;
      logic small_prime;
      logic divides;
      logic bound_ok;
      logic out_free;
   } status_type;

endpackage

/* src/tdp_rem.sv */
module tdp_rem #(
   parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  busy,
   output logic                  rem_zero
);

   localparam int CNT_BITS = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [VALUE_BITS-1:0] div_ff, div_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;

   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;

   // Bring down the next dividend bit and trial-subtract the divisor
   always_comb begin
      shifted = {rem_ff, dvd_ff[VALUE_BITS-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
   end

   // Restoring remainder, one bit per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VALUE_BITS - 1);
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
         dvd_in = {dvd_ff[VALUE_BITS-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

/* src/tdp_dpath.sv */
module tdp_dpath #(
   parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tdp_pkg::cmd_type      cmd,
   output tdp_pkg::status_type   status,
   input  logic [VALUE_BITS-1:0] req_candidate,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_tested_value,
   output logic                  rsp_prime_flag
);

   localparam int SQ_BITS = VALUE_BITS + 2;

   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic                  verdict_ff, verdict_in;
   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic                  out_flag_ff, out_flag_in;

   logic [SQ_BITS-1:0]    d_wide;
   logic                  rem_start;
   logic [VALUE_BITS-1:0] dividend;
   logic [VALUE_BITS-1:0] div_a, div_b;
   logic                  busy_a, busy_b;
   logic                  zero_a, zero_b;
   logic                  out_free;

   // Pick operands for the two remainder units
   always_comb begin
      rem_start = cmd.load | cmd.start_pair;
      dividend  = cmd.load ? req_candidate : n_ff;
      div_a     = cmd.load ? VALUE_BITS'(tdp_pkg::BASE_DIVISOR_A) : d_ff;
      div_b     = cmd.load ? VALUE_BITS'(tdp_pkg::BASE_DIVISOR_B)
                           : d_ff + VALUE_BITS'(tdp_pkg::PAIR_OFFSET);
   end

   tdp_rem #(.VALUE_BITS(VALUE_BITS)) u_rem_a (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (dividend),
      .divisor  (div_a),
      .busy     (busy_a),
      .rem_zero (zero_a)
   );

   tdp_rem #(.VALUE_BITS(VALUE_BITS)) u_rem_b (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (dividend),
      .divisor  (div_b),
      .busy     (busy_b),
      .rem_zero (zero_b)
   );

   // Candidate, divisor and running square
   always_comb begin
      d_wide = {2'b00, d_ff};
      n_in   = n_ff;
      d_in   = d_ff;
      sq_in  = sq_ff;
      if (cmd.load) begin
         n_in  = req_candidate;
         d_in  = VALUE_BITS'(tdp_pkg::FIRST_DIVISOR);
         sq_in = SQ_BITS'(tdp_pkg::FIRST_SQUARE);
      end else if (cmd.step) begin
         d_in  = d_ff + VALUE_BITS'(tdp_pkg::DIVISOR_STRIDE);
         sq_in = sq_ff + (d_wide << 3) + (d_wide << 2) + SQ_BITS'(tdp_pkg::SQUARE_STEP);
      end
   end

   // Hold the verdict until it is handed to the output register
   always_comb begin
      verdict_in = cmd.set_verdict ? cmd.verdict : verdict_ff;
   end

   // Output register: free when empty or when its transaction completes
   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_flag_in  = out_flag_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_value_in = n_ff;
         out_flag_in  = verdict_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      verdict_ff   <= verdict_in;
      out_value_ff <= out_value_in;
      out_flag_ff  <= out_flag_in;
   end

   // Report to the controller
   always_comb begin
      status.rem_done    = !busy_a && !busy_b;
      status.trivial     = (n_ff >> 2) == '0;
      status.small_prime = n_ff[1];
      status.divides     = zero_a || zero_b;
      status.bound_ok    = sq_ff <= {2'b00, n_ff};
      status.out_free    = out_free;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tested_value = out_value_ff;
   assign rsp_prime_flag   = out_flag_ff;

endmodule

/* src/tdp_ctrl.sv */
module tdp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tdp_pkg::status_type status,
   output tdp_pkg::cmd_type    cmd
);

   tdp_pkg::ctrl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tdp_pkg::ST_BASE_WAIT;
            end
         end
         tdp_pkg::ST_BASE_WAIT: begin
            if (status.rem_done) begin
               if (status.trivial || status.divides) begin
                  state_in = tdp_pkg::ST_EMIT;
               end else begin
                  state_in = tdp_pkg::ST_BOUND;
               end
            end
         end
         tdp_pkg::ST_BOUND: begin
            if (status.bound_ok) begin
               state_in = tdp_pkg::ST_PAIR_WAIT;
            end else begin
               state_in = tdp_pkg::ST_EMIT;
            end
         end
         tdp_pkg::ST_PAIR_WAIT: begin
            if (status.rem_done) begin
               if (status.divides) begin
                  state_in = tdp_pkg::ST_EMIT;
               end else begin
                  state_in = tdp_pkg::ST_BOUND;
               end
            end
         end
         tdp_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = tdp_pkg::ST_IDLE;
            end
         end
         default: state_in = tdp_pkg::ST_IDLE;
      endcase
   end

   // Commands and input handshake
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         tdp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         tdp_pkg::ST_BASE_WAIT: begin
            if (status.rem_done) begin
               if (status.trivial) begin
                  cmd.set_verdict = 1'b1;
                  cmd.verdict     = status.small_prime;
               end else if (status.divides) begin
                  cmd.set_verdict = 1'b1;
                  cmd.verdict     = 1'b0;
               end
            end
         end
         tdp_pkg::ST_BOUND: begin
            if (status.bound_ok) begin
               cmd.start_pair = 1'b1;
            end else begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b1;
            end
         end
         tdp_pkg::ST_PAIR_WAIT: begin
            if (status.rem_done) begin
               if (status.divides) begin
                  cmd.set_verdict = 1'b1;
                  cmd.verdict     = 1'b0;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         tdp_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/trial_division_primality_unit.sv */
// Trial-division primality tester (6k-1 / 6k+1). Each candidate accepted on the req_
// channel yields one rsp_ transaction carrying the candidate unchanged and a prime flag.
// Two bit-serial remainder units work side by side. The load starts one pass screening
// for factors 2 and 3; each divisor pair d, d+2 then takes a bound check against a
// running square of d, the division and the read of the remainders. Pairs are tried
// while the square does not exceed the candidate; for 32-bit primes near the top of
// the range about 10900 pairs are tried. Candidates 0 to 3 and multiples of 2 or 3
// finish after the screening pass alone.
// One item is worked on at a time; a finished result sits in an output register, so the
// next candidate is taken while it waits to be collected.
module trial_division_primality_unit #(
   parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_candidate,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_tested_value,
   output logic                  rsp_prime_flag
);

   tdp_pkg::cmd_type    cmd;
   tdp_pkg::status_type status;

   // Sequence the test
   tdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold operands, divide and drive the result
   tdp_dpath #(.VALUE_BITS(VALUE_BITS)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_candidate    (req_candidate),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tested_value (rsp_tested_value),
      .rsp_prime_flag   (rsp_prime_flag)
   );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

   localparam int W = tdp_pkg::VALUE_BITS_DEF;

   typedef logic [W-1:0] value_type;

   typedef struct {
      value_type value;
      logic      prime;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid     = 1'b0;
   logic      req_stall;
   value_type req_candidate = '0;
   logic      rsp_valid;
   logic      rsp_stall     = 1'b0;
   value_type rsp_tested_value;
   logic      rsp_prime_flag;

   value_type   pending_candidates[$];
   verdict_type expected_verdicts[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;

   trial_division_primality_unit #(
      .VALUE_BITS (W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_candidate    (req_candidate),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tested_value (rsp_tested_value),
      .rsp_prime_flag   (rsp_prime_flag)
   );

   always #5 clock = ~clock;

   // Screen 0..3 and multiples of 2 and 3, then try pairs 6k-1 / 6k+1 while d*d <= n
   function automatic logic predict_primality(input value_type cand);
      longint unsigned n;
      longint unsigned d;
      n = longint'(cand);
      if (n <= 3) return (n > 1);
      if ((n % 2) == 0 || (n % 3) == 0) return 1'b0;
      for (d = 5; d <= n / d; d += 6) begin
         if ((n % d) == 0 || (n % (d + 2)) == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Small values most often, some wider ones, full-width values with a small factor,
   // and squares or twin products that land right on the divisor bound
   function automatic value_type pick_candidate();
      int unsigned small_factors[6] = '{2, 3, 5, 7, 11, 13};
      int unsigned sel;
      int unsigned bits;
      int unsigned k;
      int unsigned m;
      value_type   r;
      sel = $urandom_range(99);
      if (sel < 45) begin
         bits = $urandom_range(16, 2);
         r = $urandom() & ((32'h1 << bits) - 1);
      end else if (sel < 65) begin
         bits = $urandom_range(20, 17);
         r = $urandom() & ((32'h1 << bits) - 1);
      end else if (sel < 82) begin
         r = $urandom();
         k = small_factors[$urandom_range(5)];
         r = r - (r % k);
      end else begin
         m = $urandom_range(1000, 5);
         r = ($urandom_range(1) != 0) ? value_type'(m * m) : value_type'(m * (m + 2));
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input value_type got,
                                  input value_type want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Drive the request channel: hold a stalled transaction, otherwise present the next one
   always @(posedge clock) begin
      verdict_type v;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            v.value = req_candidate;
            v.prime = predict_primality(req_candidate);
            expected_verdicts.insert(expected_verdicts.size(), v);
         end
         if (!req_valid || !req_stall) begin
            if (pending_candidates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_candidate <= pending_candidates.pop_front();
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Collect results against the oldest prediction and stall at random
   always @(posedge clock) begin
      verdict_type v;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tested_value, '0);
            end else begin
               v = expected_verdicts.pop_front();
               if (rsp_tested_value !== v.value)
                  report_mismatch("tested_value", rsp_tested_value, v.value);
               if (rsp_prime_flag !== v.prime)
                  report_mismatch($sformatf("prime_flag of %0d", v.value),
                                  value_type'(rsp_prime_flag), value_type'(v.prime));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Stimulus: directed corners first, then random items over four phases of sender idling and receiver stalls
   initial begin
      int unsigned idle_tab[4]  = '{0, 46, 0, 12};
      int unsigned stall_tab[4] = '{0, 0, 46, 12};
      value_type   directed[$]  = '{
         32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
         32'd25, 32'd35, 32'd49, 32'd121, 32'd143, 32'd169, 32'd289, 32'd63001,
         32'd65521, 32'd65537, 32'd16777207, 32'hFFFFFFFE, 32'hFFFFFFFF,
         32'h80000000, 32'd4294967291
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_tab[p];
         recv_stall_pct = stall_tab[p];
         if (p == 0) begin
            foreach (directed[i])
               pending_candidates.insert(pending_candidates.size(), directed[i]);
         end
         repeat (19) pending_candidates.insert(pending_candidates.size(), pick_candidate());
         // Hold off the next phase until every result of this one has come back
         while (pending_candidates.size() != 0 || req_valid || expected_verdicts.size() != 0)
            @(posedge clock);
      end
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #50000000;
      $display("FAIL");
      $finish;
   end

endmodule

/* filelist.f */
src/tdp_pkg.sv
src/tdp_rem.sv
src/tdp_dpath.sv
src/tdp_ctrl.sv
src/trial_division_primality_unit.sv
bench/tb_top.sv
